/* src/snorm_pkg.sv */
// Shared constants, types and tables for the softmax normalizer.
`default_nettype none
package snorm_pkg;

    localparam int MAX_ELEMS = 64;
    localparam int IDX_W     = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
    localparam int SCORE_W   = 16;
    localparam int PROB_W    = 16;
    localparam int EXP_W     = 17;
    localparam int SUM_W     = 23;
    localparam int NUM_W     = 34;
    localparam int QUO_W     = 17;
    localparam int DCNT_W    = 5;
    localparam int LOG2E_Q14 = 23637;
    localparam int SHIFT_LIM = 17;

    typedef enum logic [8:0] {
        S_LOAD = 9'b000000001,
        S_RD   = 9'b000000010,
        S_MUL  = 9'b000000100,
        S_INT  = 9'b000001000,
        S_SHF  = 9'b000010000,
        S_ACC  = 9'b000100000,
        S_DLD  = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    typedef struct packed {
        logic accept;
        logic vec_clr;
        logic idx_clr;
        logic idx_inc;
        logic mem_rd;
        logic mul_en;
        logic int_en;
        logic shf_en;
        logic acc_en;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic at_end;
        logic div_done;
        logic out_free;
    } status_t;

    function automatic logic [EXP_W-1:0] pow2_frac(input logic [4:0] k);
        logic [EXP_W-1:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62804;
            5'd2:    v = 17'd60098;
            5'd3:    v = 17'd57548;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* src/softmax_normalizer.sv */
// Top level of the softmax normalizer: sequencer plus datapath.
//
// Input channel: score (signed Q7.8) and is_last, handshake in_valid/in_stall.
// One word is taken per cycle while a vector loads; up to MAX_ELEMS elements
// are stored, later ones are dropped and reported through overflowed.
// The word with is_last starts the computation; in_stall stays high until
// the final probability has been loaded into the output register.
// Output channel: probability (Q0.16), last_out, overflowed, handshake
// out_valid/out_stall, one word per stored element in input order.
// Per vector: a load pass, then an exponent-sum pass (read, multiply,
// interpolate, shift, accumulate for each element), then a normalize pass
// (the exponent steps again, divider load, divider steps, output load).
// The 17-step restoring divider sets the output rate.
// A stalled output word holds; the next element is computed meanwhile and
// waits until the output register frees.
// Reset clears the vector state; the element store needs no clearing.
`default_nettype none
module softmax_normalizer
    import snorm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [SCORE_W-1:0]  score,
    input  wire logic                is_last,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [PROB_W-1:0]        probability,
    output logic                     last_out,
    output logic                     overflowed
);

    cmd_t    cmd;
    status_t status;

    snorm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .is_last  (is_last),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    snorm_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .score       (score),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .status      (status),
        .probability (probability),
        .last_out    (last_out),
        .overflowed  (overflowed),
        .out_valid   (out_valid)
    );

endmodule
`default_nettype wire

/* src/snorm_ctrl.sv */
// Sequencer for load, exponent-sum and normalize passes.
`default_nettype none
module snorm_ctrl
    import snorm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    is_last,
    output logic         in_stall,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;

    assign in_stall = (state_reg != S_LOAD);

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (is_last)
                    begin
                        cmd.idx_clr = 1'b1;
                        pass_next   = 1'b0;
                        state_next  = S_RD;
                    end
                end
            end
            S_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_INT;
            end
            S_INT:
            begin
                cmd.int_en = 1'b1;
                state_next = S_SHF;
            end
            S_SHF:
            begin
                cmd.shf_en = 1'b1;
                state_next = pass_reg ? S_DLD : S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_en = 1'b1;
                if (status.at_end)
                begin
                    cmd.idx_clr = 1'b1;
                    pass_next   = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
                state_next = S_RD;
            end
            S_DLD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.at_end)
                    begin
                        cmd.vec_clr = 1'b1;
                        state_next  = S_LOAD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

endmodule
`default_nettype wire

/* src/snorm_dp.sv */
// Element store, exponent unit, sum, divider and output word register.
`default_nettype none
module snorm_dp
    import snorm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [SCORE_W-1:0]  score,
    input  wire logic                out_stall,
    input  wire cmd_t                cmd,
    output status_t                  status,
    output logic [PROB_W-1:0]        probability,
    output logic                     last_out,
    output logic                     overflowed,
    output logic                     out_valid
);

    logic [SCORE_W-1:0]  mem [MAX_ELEMS];
    logic [SCORE_W-1:0]  rd_data_reg;
    logic signed [SCORE_W-1:0] max_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                drop_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [30:0]         prod_reg;
    logic [EXP_W-1:0]    m_reg;
    logic [4:0]          n_reg;
    logic                zero_reg;
    logic [EXP_W-1:0]    e_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    rem_reg;
    logic [QUO_W-1:0]    num_lo_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic [DCNT_W-1:0]   dcnt_reg;
    logic [PROB_W-1:0]   prob_reg;
    logic                last_reg;
    logic                over_reg;
    logic                valid_reg;

    logic                room;
    logic [SCORE_W-1:0]  diff;
    logic [16:0]         u;
    logic [8:0]          n_full;
    logic [3:0]          k;
    logic [3:0]          r;
    logic [EXP_W-1:0]    tk;
    logic [EXP_W-1:0]    tk1;
    logic [EXP_W-1:0]    tdiff;
    logic [15:0]         interp;
    logic [16:0]         interp_rnd;
    logic [NUM_W-1:0]    numer;
    logic [SUM_W:0]      trial;
    logic                qbit;

    assign room = (count_reg < CNT_W'(MAX_ELEMS));

    assign diff       = SCORE_W'($signed(max_reg) - $signed(rd_data_reg));
    assign u          = prod_reg[30:14];
    assign n_full     = u[16:8];
    assign k          = u[7:4];
    assign r          = u[3:0];
    assign tk         = pow2_frac({1'b0, k});
    assign tk1        = pow2_frac(5'({1'b0, k} + 5'd1));
    assign tdiff      = tk - tk1;
    assign interp     = 16'(tdiff[11:0] * r);
    assign interp_rnd = (17'(interp) + 17'd8) >> 4;

    assign numer = {e_reg, 16'd0} + NUM_W'(sum_reg >> 1);
    assign trial = {rem_reg, num_lo_reg[QUO_W-1]};
    assign qbit  = (trial >= {1'b0, sum_reg});

    assign status.at_end   = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));
    assign status.div_done = (dcnt_reg == DCNT_W'(QUO_W - 1));
    assign status.out_free = !valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && room)
        begin
            mem[count_reg[IDX_W-1:0]] <= score;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= 31'(diff * 15'(LOG2E_Q14));
        end
        if (cmd.int_en)
        begin
            m_reg    <= tk - interp_rnd;
            n_reg    <= n_full[4:0];
            zero_reg <= (n_full >= 9'(SHIFT_LIM));
        end
        if (cmd.shf_en)
        begin
            e_reg <= zero_reg ? '0 : (m_reg >> n_reg);
        end
        if (cmd.div_start)
        begin
            rem_reg    <= SUM_W'(numer[NUM_W-1:QUO_W]);
            num_lo_reg <= numer[QUO_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg    <= qbit ? SUM_W'(trial - {1'b0, sum_reg}) : trial[SUM_W-1:0];
            num_lo_reg <= {num_lo_reg[QUO_W-2:0], 1'b0};
            quo_reg    <= {quo_reg[QUO_W-2:0], qbit};
        end
        if (cmd.out_load)
        begin
            prob_reg <= quo_reg[QUO_W-1] ? '1 : quo_reg[PROB_W-1:0];
            last_reg <= status.at_end;
            over_reg <= drop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg   <= 16'sh8000;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            idx_reg   <= '0;
            sum_reg   <= '0;
            dcnt_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.vec_clr)
            begin
                max_reg   <= 16'sh8000;
                count_reg <= '0;
                drop_reg  <= 1'b0;
                sum_reg   <= '0;
            end
            else
            begin
                if (cmd.accept)
                begin
                    if (room)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        if ($signed(score) > max_reg)
                        begin
                            max_reg <= $signed(score);
                        end
                    end
                    else
                    begin
                        drop_reg <= 1'b1;
                    end
                end
                if (cmd.acc_en)
                begin
                    sum_reg <= sum_reg + SUM_W'(e_reg);
                end
            end
            if (cmd.idx_clr || cmd.vec_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.div_start)
            begin
                dcnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
            end
            if (cmd.out_load)
            begin
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign probability = prob_reg;
    assign last_out    = last_reg;
    assign overflowed  = over_reg;
    assign out_valid   = valid_reg;

endmodule
`default_nettype wire

/* src/snorm_checker.sv */
// Port-level checks for the softmax normalizer, bound to the top level.
`default_nettype none
module snorm_checker
    import snorm_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                is_last,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic [PROB_W-1:0]   probability,
    input wire logic                last_out,
    input wire logic                overflowed
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(probability)
            && $stable(last_out) && $stable(overflowed))
        else $error("stalled output word changed");

    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && is_last |=> in_stall)
        else $error("input not stalled after final element");

    a_no_out_while_loading: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !is_last && !out_valid |=> !out_valid)
        else $error("output word during vector load");

endmodule

bind softmax_normalizer snorm_checker u_snorm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .is_last     (is_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .probability (probability),
    .last_out    (last_out),
    .overflowed  (overflowed)
);
`default_nettype wire

/* sim/tb.sv */
// Testbench for softmax_normalizer: directed and random vectors checked against a fixed-point softmax predictor.
`default_nettype none
module tb;
    import snorm_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [SCORE_W-1:0]  score;
    logic                is_last;
    logic                out_valid;
    logic                out_stall;
    logic [PROB_W-1:0]   probability;
    logic                last_out;
    logic                overflowed;

    typedef struct packed {
        logic [15:0] score;
        logic        is_last;
    } elem_t;

    typedef struct packed {
        logic [15:0] probability;
        logic        last_out;
        logic        overflowed;
    } prob_t;

    elem_t pending_words[$];
    prob_t expected_probs[$];

    logic [15:0] vec_scores[MAX_ELEMS];
    int          vec_count;
    int          vec_max;
    logic        vec_dropped;

    int  errors;
    int  cycles;
    bit  calm;
    int  in_gap;
    int  out_gap;

    softmax_normalizer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .score       (score),
        .is_last     (is_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .probability (probability),
        .last_out    (last_out),
        .overflowed  (overflowed)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [16:0] exp_of_gap(input int mx, input int x);
        logic [15:0] d;
        logic [31:0] u;
        int          n;
        int          k;
        int          r;
        int          m;
        d = 16'(mx - x);
        u = (32'(d) * 32'd23637) >> 14;
        n = int'(u >> 8);
        k = int'(u[7:4]);
        r = int'(u[3:0]);
        if (n >= 17)
        begin
            return 17'd0;
        end
        m = int'(pow2_frac(5'(k)));
        m = m - (((m - int'(pow2_frac(5'(k + 1)))) * r + 8) >> 4);
        return 17'(m >> n);
    endfunction

    task automatic predict_word(input elem_t w);
        logic [22:0] total;
        logic [63:0] p;
        logic [16:0] e;
        if (vec_count < MAX_ELEMS)
        begin
            vec_scores[vec_count] = w.score;
            vec_count++;
            if ($signed(w.score) > vec_max)
            begin
                vec_max = $signed(w.score);
            end
        end
        else
        begin
            vec_dropped = 1'b1;
        end
        if (!w.is_last)
        begin
            return;
        end
        total = '0;
        for (int i = 0; i < vec_count; i++)
        begin
            total += 23'(exp_of_gap(vec_max, $signed(vec_scores[i])));
        end
        for (int i = 0; i < vec_count; i++)
        begin
            e = exp_of_gap(vec_max, $signed(vec_scores[i]));
            p = ((64'(e) << 16) + 64'(total >> 1)) / 64'(total);
            if (p > 64'd65535)
            begin
                p = 64'd65535;
            end
            expected_probs.insert(expected_probs.size(),
                                  {p[15:0], 1'(i == vec_count - 1), vec_dropped});
        end
        vec_count   = 0;
        vec_max     = -32768;
        vec_dropped = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic logic [15:0] rand_score(input int spread);
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'h8000;
            2: return 16'h7fff;
            default: return 16'($signed(16'h0000) + $signed(16'($urandom_range(0, spread)))
                                - 16'(spread / 2));
        endcase
    endfunction

    task automatic queue_vector(input int len, input int spread);
        for (int i = 0; i < len; i++)
        begin
            pending_words.insert(pending_words.size(),
                                 {rand_score(spread), 1'(i == len - 1)});
        end
    endtask

    // drive
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            score    <= '0;
            is_last  <= 1'b0;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_word({score, is_last});
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    in_gap   <= $urandom_range(1, 14) - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    elem_t w;
                    w = pending_words.pop_front();
                    in_valid <= 1'b1;
                    score    <= w.score;
                    is_last  <= w.is_last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and output stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_probs.size() == 0)
                begin
                    report_mismatch("unexpected word", probability, -1);
                end
                else
                begin
                    prob_t x;
                    x = expected_probs.pop_front();
                    if (probability !== x.probability)
                        report_mismatch("probability", probability, x.probability);
                    if (last_out !== x.last_out)
                        report_mismatch("last_out", last_out, x.last_out);
                    if (overflowed !== x.overflowed)
                        report_mismatch("overflowed", overflowed, x.overflowed);
                end
            end
            if (out_gap > 0)
            begin
                out_gap   <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_gap   <= $urandom_range(1, 14) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int sent;
        errors      = 0;
        cycles      = 0;
        calm        = 0;
        vec_count   = 0;
        vec_max     = -32768;
        vec_dropped = 1'b0;
        rst_n       = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // single element, extremes, all equal, wide spread
        pending_words.insert(pending_words.size(), {16'h0000, 1'b1});
        pending_words.insert(pending_words.size(), {16'h8000, 1'b1});
        pending_words.insert(pending_words.size(), {16'h7fff, 1'b0});
        pending_words.insert(pending_words.size(), {16'h8000, 1'b1});
        pending_words.insert(pending_words.size(), {16'h0100, 1'b0});
        pending_words.insert(pending_words.size(), {16'h0100, 1'b0});
        pending_words.insert(pending_words.size(), {16'h0100, 1'b1});
        pending_words.insert(pending_words.size(), {16'hffff, 1'b0});
        pending_words.insert(pending_words.size(), {16'h5555, 1'b0});
        pending_words.insert(pending_words.size(), {16'haaaa, 1'b0});
        pending_words.insert(pending_words.size(), {16'h0000, 1'b1});
        // capacity exceeded, last three elements dropped
        for (int i = 0; i < MAX_ELEMS + 3; i++)
        begin
            pending_words.insert(pending_words.size(),
                                 {16'(i * 37), 1'(i == MAX_ELEMS + 2)});
        end

        sent = pending_words.size();
        while (sent < 95)
        begin
            int len;
            case ($urandom_range(0, 9))
                0: len = $urandom_range(MAX_ELEMS - 2, MAX_ELEMS + 4);
                1: len = 1;
                default: len = $urandom_range(2, 8);
            endcase
            queue_vector(len, $urandom_range(0, 3) == 0 ? 65535 : 2048);
            sent += len;
        end

        wait (pending_words.size() == 0 && !in_valid && expected_probs.size() == 0);
        calm = 1;
        queue_vector(5, 1024);
        wait (pending_words.size() == 0);
        @(posedge clk);
        wait (!in_valid && expected_probs.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
